/* design/wglm_pkg.sv */
// ----------------------------------------------------------------------------
// wglm_pkg: shared constants for the graph Laplacian matrix-vector block
// Sizes, field widths, operation, status and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package wglm_pkg;

  localparam int MAX_POSES   = 1024;
  localparam int MAX_DIM     = 3;
  localparam int STORE_DEPTH = MAX_POSES * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int OP_W     = 2;
  localparam int POSE_W   = 10;
  localparam int COMP_W   = 2;
  localparam int X_W      = 32;
  localparam int TAU_W    = 24;
  localparam int WEIGHT_W = 17;
  localparam int STATUS_W = 2;
  localparam int Y_W      = 48;

  localparam int DIM_W      = 2;
  localparam int POSE_CNT_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_EDGE = 2'd1;
  localparam logic [OP_W-1:0] OP_DIAG = 2'd2;
  localparam logic [OP_W-1:0] OP_READ = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ANCHOR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_WEIGHT = 2'd2;

  localparam logic [DIM_W-1:0]      DIM_RESET   = DIM_W'(MAX_DIM);
  localparam logic [POSE_CNT_W-1:0] POSES_RESET = POSE_CNT_W'(MAX_POSES);
  localparam logic [TAU_W-1:0]      TAU_MAX     = '1;

endpackage

`default_nettype wire

/* design/wglm_if.sv */
// ----------------------------------------------------------------------------
// wglm channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface wglm_item_if import wglm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            op;
  logic [POSE_W-1:0]          pose_index;
  logic [COMP_W-1:0]          component;
  logic signed [X_W-1:0]      x_value;
  logic [POSE_W-1:0]          first_pose;
  logic [POSE_W-1:0]          second_pose;
  logic [TAU_W-1:0]           tau_value;
  logic [WEIGHT_W-1:0]        weight_value;

  modport source (output valid, op, pose_index, component, x_value, first_pose,
                  second_pose, tau_value, weight_value, input ready);
  modport sink (input valid, op, pose_index, component, x_value, first_pose,
                second_pose, tau_value, weight_value, output ready);
endinterface

interface wglm_result_if import wglm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic                  read_valid;
  logic signed [Y_W-1:0] read_value;

  modport source (output valid, status, read_valid, read_value, input ready);
  modport sink (input valid, status, read_valid, read_value, output ready);
endinterface

interface wglm_cfg_if import wglm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/weighted_graph_laplacian_matvec.sv */
// Items are handled one at a time: no new item is accepted until the
//   previous one has left its completion step. An edge apply does two x
//   reads and two y read-modify-writes per component through the single read
//   port of each memory; an edge diagonal does only the y read-modify-writes.
// Reset: registers take dimension 3, pose_count 1024, use_weight 0; then a
//   clearing pass over all 3072 y entries zeroes y while no item is accepted.
// ----------------------------------------------------------------------------
// weighted_graph_laplacian_matvec
// Applies the anchored translation Laplacian of a pose graph edge by edge,
// with x and y held in single-port-read synchronous memories.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_graph_laplacian_matvec import wglm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  wglm_item_if.sink     item,
  wglm_result_if.source result,
  wglm_cfg_if.sink      cfg
);

  localparam int ST_W   = 4;
  localparam int PROD_W = TAU_W + X_W;
  localparam int P_W    = PROD_W - 16;
  localparam int D_W    = P_W + 2;
  localparam int WP_W   = TAU_W + WEIGHT_W;

  localparam logic [ST_W-1:0] S_IDLE = 4'd0;
  localparam logic [ST_W-1:0] S_TAU  = 4'd1;
  localparam logic [ST_W-1:0] S_RX1  = 4'd2;
  localparam logic [ST_W-1:0] S_RX2  = 4'd3;
  localparam logic [ST_W-1:0] S_SUB  = 4'd4;
  localparam logic [ST_W-1:0] S_MUL  = 4'd5;
  localparam logic [ST_W-1:0] S_RY1  = 4'd6;
  localparam logic [ST_W-1:0] S_WY1  = 4'd7;
  localparam logic [ST_W-1:0] S_RY2  = 4'd8;
  localparam logic [ST_W-1:0] S_WY2  = 4'd9;
  localparam logic [ST_W-1:0] S_LOAD = 4'd10;
  localparam logic [ST_W-1:0] S_RD   = 4'd11;
  localparam logic [ST_W-1:0] S_RDW  = 4'd12;
  localparam logic [ST_W-1:0] S_DONE = 4'd13;

  localparam logic signed [Y_W:0] Y_MAX = {2'b00, {(Y_W-1){1'b1}}};
  localparam logic signed [Y_W:0] Y_MIN = {2'b11, {(Y_W-1){1'b0}}};

  // configuration
  logic [DIM_W-1:0]      dimension;
  logic [POSE_CNT_W-1:0] pose_count;
  logic                  use_weight;
  logic [DIM_W-1:0]      dim_eff;
  logic [POSE_CNT_W-1:0] poses_eff;

  // control
  logic [ST_W-1:0]   state, state_next;
  logic              clr_busy;
  logic [ADDR_W-1:0] clr_addr;
  logic              in_ready;
  logic              accept;
  logic              out_free;
  logic [COMP_W-1:0] comp_cnt;
  logic              last_comp;

  // item context
  logic [OP_W-1:0]       op_r;
  logic [ADDR_W-1:0]     base1, base2;
  logic                  p1_zero, p2_zero;
  logic [X_W-1:0]        xval_r;
  logic [TAU_W-1:0]      tau_r, t_r;
  logic [WEIGHT_W-1:0]   w_r;
  logic [STATUS_W-1:0]   res_status;
  logic                  res_read_valid;
  logic [Y_W-1:0]        res_value;

  // datapath
  logic signed [X_W-1:0] x1_r;
  logic                  u_neg;
  logic [X_W-1:0]        u_mag;
  logic [PROD_W-1:0]     prod_r;
  logic signed [D_W-1:0] d1_r, d2_r;

  // memories
  logic [X_W-1:0]    x_mem [STORE_DEPTH];
  logic [Y_W-1:0]    y_mem [STORE_DEPTH];
  logic              x_we, y_we;
  logic [ADDR_W-1:0] x_waddr, x_raddr, y_waddr, y_raddr;
  logic [X_W-1:0]    x_rdata;
  logic [Y_W-1:0]    y_rdata, y_wdata;

  // output register
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic                out_read_valid;
  logic [Y_W-1:0]      out_read_value;

  function automatic logic [Y_W-1:0] sat_add(input logic [Y_W-1:0] a,
                                             input logic signed [D_W-1:0] b);
    logic signed [Y_W:0] s;
    s = $signed({a[Y_W-1], a}) + (Y_W+1)'(b);
    if (s > Y_MAX)      sat_add = Y_MAX[Y_W-1:0];
    else if (s < Y_MIN) sat_add = Y_MIN[Y_W-1:0];
    else                sat_add = s[Y_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension  <= DIM_RESET;
      pose_count <= POSES_RESET;
      use_weight <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DIMENSION:  dimension  <= cfg.data[DIM_W-1:0];
        REG_POSE_COUNT: pose_count <= cfg.data[POSE_CNT_W-1:0];
        REG_USE_WEIGHT: use_weight <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dimension == '0)                       dim_eff = DIM_W'(1);
    else if (dimension > DIM_W'(MAX_DIM))      dim_eff = DIM_W'(MAX_DIM);
    else                                       dim_eff = dimension;
    if (pose_count == '0)                      poses_eff = POSE_CNT_W'(1);
    else if (pose_count > POSE_CNT_W'(MAX_POSES)) poses_eff = POSE_CNT_W'(MAX_POSES);
    else                                       poses_eff = pose_count;
  end

  // --------------------------------------------------------------------------
  // handshakes
  // --------------------------------------------------------------------------
  assign in_ready   = (state == S_IDLE) && !clr_busy;
  assign item.ready = in_ready;
  assign accept     = item.valid && in_ready;
  assign out_free   = !out_valid || result.ready;
  assign last_comp  = (DIM_W'(comp_cnt) + DIM_W'(1)) >= dim_eff;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.op == OP_LOAD || item.op == OP_READ) begin
            if ({1'b0, item.pose_index} >= poses_eff || item.component >= dim_eff ||
                item.pose_index == '0) begin
              state_next = S_DONE;
            end else if (item.op == OP_LOAD) begin
              state_next = S_LOAD;
            end else begin
              state_next = S_RD;
            end
          end else if ({1'b0, item.first_pose} >= poses_eff ||
                       {1'b0, item.second_pose} >= poses_eff) begin
            state_next = S_DONE;
          end else begin
            state_next = S_TAU;
          end
        end
      end
      S_TAU:  state_next = (op_r == OP_EDGE) ? S_RX1 : S_RY1;
      S_RX1:  state_next = S_RX2;
      S_RX2:  state_next = S_SUB;
      S_SUB:  state_next = S_MUL;
      S_MUL:  state_next = S_RY1;
      S_RY1:  state_next = S_WY1;
      S_WY1:  state_next = S_RY2;
      S_RY2:  state_next = S_WY2;
      S_WY2: begin
        if (last_comp) state_next = S_DONE;
        else           state_next = (op_r == OP_EDGE) ? S_RX1 : S_RY1;
      end
      S_LOAD: state_next = S_DONE;
      S_RD:   state_next = S_RDW;
      S_RDW:  state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clr_busy) begin
        clr_addr <= clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) clr_busy <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // item context and arithmetic
  // --------------------------------------------------------------------------
  logic [WP_W-1:0]   wprod;
  logic [WP_W-17:0]  tw;
  logic [P_W-1:0]    p_mag;
  logic signed [D_W-1:0] d_edge;
  logic signed [X_W:0]   u_full;
  logic signed [X_W-1:0] x2_val;

  always_comb begin
    wprod  = WP_W'(tau_r) * WP_W'(w_r) + WP_W'(32768);
    tw     = wprod[WP_W-1:16];
    p_mag  = P_W'((prod_r + PROD_W'(32768)) >> 16);
    d_edge = u_neg ? -$signed({2'b00, p_mag}) : $signed({2'b00, p_mag});
    x2_val = p2_zero ? '0 : $signed(x_rdata);
    u_full = (X_W+1)'(x2_val) - (X_W+1)'(x1_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_cnt <= '0;
    end else if (accept) begin
      comp_cnt <= '0;
    end else if (state == S_WY2) begin
      comp_cnt <= last_comp ? '0 : comp_cnt + COMP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_r           <= item.op;
          xval_r         <= item.x_value;
          tau_r          <= item.tau_value;
          w_r            <= item.weight_value;
          p1_zero        <= item.first_pose == '0;
          p2_zero        <= item.second_pose == '0;
          res_read_valid <= 1'b0;
          res_value      <= '0;
          if (item.op == OP_LOAD || item.op == OP_READ) begin
            base1 <= ADDR_W'(item.pose_index) * ADDR_W'(MAX_DIM) +
                     ADDR_W'(item.component);
            if ({1'b0, item.pose_index} >= poses_eff || item.component >= dim_eff)
              res_status <= ST_RANGE;
            else if (item.pose_index == '0)
              res_status <= ST_ANCHOR;
            else
              res_status <= ST_OK;
          end else begin
            base1 <= ADDR_W'(item.first_pose) * ADDR_W'(MAX_DIM);
            base2 <= ADDR_W'(item.second_pose) * ADDR_W'(MAX_DIM);
            if ({1'b0, item.first_pose} >= poses_eff ||
                {1'b0, item.second_pose} >= poses_eff)
              res_status <= ST_RANGE;
            else
              res_status <= ST_OK;
          end
        end
      end
      S_TAU: begin
        if (use_weight) t_r <= tw[TAU_W] ? TAU_MAX : tw[TAU_W-1:0];
        else            t_r <= tau_r;
      end
      S_RX2: x1_r <= p1_zero ? '0 : $signed(x_rdata);
      S_SUB: begin
        u_neg <= u_full < 0;
        u_mag <= X_W'(u_full < 0 ? -u_full : u_full);
      end
      S_MUL: prod_r <= PROD_W'(t_r) * PROD_W'(u_mag);
      S_RY1: begin
        if (op_r == OP_EDGE) begin
          d2_r <= d_edge;
          d1_r <= -d_edge;
        end else begin
          d2_r <= D_W'(t_r);
          d1_r <= D_W'(t_r);
        end
      end
      S_RDW: begin
        res_read_valid <= 1'b1;
        res_value      <= y_rdata;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // memories
  // --------------------------------------------------------------------------
  always_comb begin
    x_we    = state == S_LOAD;
    x_waddr = base1;
    x_raddr = (state == S_RX2) ? base2 + ADDR_W'(comp_cnt) : base1 + ADDR_W'(comp_cnt);
    y_raddr = (state == S_RY2) ? base2 + ADDR_W'(comp_cnt) : base1 + ADDR_W'(comp_cnt);
    y_we    = 1'b0;
    y_waddr = base1 + ADDR_W'(comp_cnt);
    y_wdata = '0;
    if (clr_busy) begin
      y_we    = 1'b1;
      y_waddr = clr_addr;
    end else if (state == S_WY1) begin
      y_we    = !p1_zero;
      y_wdata = sat_add(y_rdata, d1_r);
    end else if (state == S_WY2) begin
      y_we    = !p2_zero;
      y_waddr = base2 + ADDR_W'(comp_cnt);
      y_wdata = sat_add(y_rdata, d2_r);
    end else if (state == S_RDW) begin
      // read and clear
      y_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (x_we) x_mem[x_waddr] <= xval_r;
    x_rdata <= x_mem[x_raddr];
  end

  always_ff @(posedge clk) begin
    if (y_we) y_mem[y_waddr] <= y_wdata;
    y_rdata <= y_mem[y_raddr];
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_status     <= res_status;
      out_read_valid <= res_read_valid;
      out_read_value <= res_value;
    end
  end

  assign result.valid      = out_valid;
  assign result.status     = out_status;
  assign result.read_valid = out_read_valid;
  assign result.read_value = out_read_value;

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !item.ready)
    else $error("item accepted during y clearing pass");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == S_DONE)
    else $error("result raised outside completion step");

  a_read_value_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.read_valid |-> result.read_value == '0)
    else $error("read_value nonzero without read_valid");

  a_comp_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_WY2 |-> DIM_W'(comp_cnt) < dim_eff)
    else $error("component counter beyond dimension");

  a_anchor_untouched: assert property (@(posedge clk) disable iff (rst)
    y_we && !clr_busy |-> y_waddr >= ADDR_W'(MAX_DIM))
    else $error("y write to anchor pose");
`endif

endmodule

`default_nettype wire

/* verif/tb_weighted_graph_laplacian_matvec.sv */
// ----------------------------------------------------------------------------
// tb_weighted_graph_laplacian_matvec: self-checking bench for the Laplacian
// matrix-vector block. A scoreboard class predicts every status and y read
// from its own copy of x, y and the registers. Directed extremes come first,
// then random segments across several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_weighted_graph_laplacian_matvec;
  import wglm_pkg::*;

  typedef struct {
    logic [OP_W-1:0]       op;
    logic [POSE_W-1:0]     pose_index;
    logic [COMP_W-1:0]     component;
    logic signed [X_W-1:0] x_value;
    logic [POSE_W-1:0]     first_pose;
    logic [POSE_W-1:0]     second_pose;
    logic [TAU_W-1:0]      tau_value;
    logic [WEIGHT_W-1:0]   weight_value;
  } graph_item_t;

  typedef struct {
    logic [STATUS_W-1:0]   status;
    logic                  read_valid;
    logic signed [Y_W-1:0] read_value;
  } graph_outcome_t;

  class laplacian_board;
    int fails;
    int x_mem [STORE_DEPTH];
    bit x_set [STORE_DEPTH];
    longint y_mem [STORE_DEPTH];
    logic [DIM_W-1:0] dim_reg;
    logic [POSE_CNT_W-1:0] poses_reg;
    logic weight_on;
    graph_outcome_t outcome_q [$];

    function new();
      fails = 0;
      foreach (y_mem[k]) begin
        y_mem[k] = 0;
        x_mem[k] = 0;
        x_set[k] = 1'b0;
      end
      dim_reg = DIM_RESET;
      poses_reg = POSES_RESET;
      weight_on = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DIMENSION:  dim_reg = data[DIM_W-1:0];
        REG_POSE_COUNT: poses_reg = data[POSE_CNT_W-1:0];
        REG_USE_WEIGHT: weight_on = data[0];
        default: ;
      endcase
    endfunction

    function int dims_used();
      if (dim_reg == 0) return 1;
      if (dim_reg > MAX_DIM) return MAX_DIM;
      return int'(dim_reg);
    endfunction

    function int poses_used();
      if (poses_reg == 0) return 1;
      if (poses_reg > MAX_POSES) return MAX_POSES;
      return int'(poses_reg);
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    // anchor pose reads as zero
    function longint x_of(logic [POSE_W-1:0] pose, int c);
      if (pose == 0) return 0;
      return longint'(x_mem[int'(pose) * MAX_DIM + c]);
    endfunction

    // Q24.32 product to Q24.16, halves rounded away from zero
    function longint scaled_step(logic [TAU_W-1:0] t, longint u);
      longint unsigned mag;
      longint unsigned p;
      mag = (u < 0) ? -u : u;
      p = (64'(t) * mag + 64'd32768) >> 16;
      return (u < 0) ? -longint'(p) : longint'(p);
    endfunction

    function longint clamp_y(longint s);
      longint top;
      top = 64'sh0000_7FFF_FFFF_FFFF;
      if (s > top) return top;
      if (s < -top - 1) return -top - 1;
      return s;
    endfunction

    function void note_item(graph_item_t it);
      graph_outcome_t want;
      int dim;
      int np;
      int k;
      int c;
      longint u;
      longint d1;
      longint d2;
      longint unsigned tw;
      logic [TAU_W-1:0] t;
      want.status = ST_OK;
      want.read_valid = 1'b0;
      want.read_value = '0;
      dim = dims_used();
      np = poses_used();
      if (it.op == OP_LOAD || it.op == OP_READ) begin
        if (it.pose_index >= np || it.component >= dim) begin
          want.status = ST_RANGE;
        end else if (it.pose_index == 0) begin
          want.status = ST_ANCHOR;
        end else begin
          k = int'(it.pose_index) * MAX_DIM + int'(it.component);
          if (it.op == OP_LOAD) begin
            x_mem[k] = it.x_value;
            x_set[k] = 1'b1;
          end else begin
            want.read_valid = 1'b1;
            want.read_value = y_mem[k][Y_W-1:0];
            y_mem[k] = 0;
          end
        end
      end else if (it.first_pose >= np || it.second_pose >= np) begin
        want.status = ST_RANGE;
      end else begin
        t = it.tau_value;
        if (weight_on) begin
          tw = (64'(it.tau_value) * 64'(it.weight_value) + 64'd32768) >> 16;
          t = (tw > 64'(TAU_MAX)) ? TAU_MAX : tw[TAU_W-1:0];
        end
        for (c = 0; c < dim; c++) begin
          if (it.op == OP_EDGE) begin
            u = x_of(it.second_pose, c) - x_of(it.first_pose, c);
            d2 = scaled_step(t, u);
            d1 = -d2;
          end else begin
            d1 = longint'(t);
            d2 = longint'(t);
          end
          if (it.first_pose != 0) begin
            k = int'(it.first_pose) * MAX_DIM + c;
            y_mem[k] = clamp_y(y_mem[k] + d1);
          end
          if (it.second_pose != 0) begin
            k = int'(it.second_pose) * MAX_DIM + c;
            y_mem[k] = clamp_y(y_mem[k] + d2);
          end
        end
      end
      outcome_q.push_back(want);
    endfunction

    task report_mismatch(string msg);
      fails++;
      $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    task check_result(logic [STATUS_W-1:0] st, logic rv, logic signed [Y_W-1:0] val);
      graph_outcome_t want;
      if (outcome_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, status %0d", st));
      end else begin
        want = outcome_q.pop_front();
        if (st !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", st, want.status));
        if (rv !== want.read_valid)
          report_mismatch($sformatf("read_valid %b, want %b", rv, want.read_valid));
        if (val !== want.read_value)
          report_mismatch($sformatf("read_value %h, want %h", val, want.read_value));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  int send_gap;
  int recv_gap;
  laplacian_board board;

  int seg_dim [9] = '{3, 2, 0, 1, 3, 3, 2, 3, 3};
  int seg_poses [9] = '{1024, 16, 0, 1024, 2047, 8, 1023, 1024, 64};
  int seg_weight [9] = '{0, 1, 0, 1, 1, 0, 0, 1, 0};
  int seg_len [9] = '{80, 70, 20, 70, 70, 70, 70, 40, 70};

  wglm_item_if item_ch ();
  wglm_result_if result_ch ();
  wglm_cfg_if cfg_ch ();

  weighted_graph_laplacian_matvec uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        board.check_result(result_ch.status, result_ch.read_valid, result_ch.read_value);
      end
      result_ch.ready <= ($urandom_range(99, 0) >= recv_gap);
    end
  end

  function automatic logic signed [X_W-1:0] rand_x();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(3, 0))
      1: return {{12{r[19]}}, r[19:0]};
      2: begin
        case ($urandom_range(4, 0))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0000_8000;
          default: return 32'hFFFF_8000;
        endcase
      end
      default: return r;
    endcase
  endfunction

  function automatic logic [TAU_W-1:0] rand_tau();
    case ($urandom_range(4, 0))
      0: return TAU_W'($urandom_range(65536, 0));
      1: return TAU_MAX;
      2: return TAU_W'($urandom_range(1, 0));
      default: return TAU_W'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    int r;
    r = $urandom_range(99, 0);
    if (r < 20) return 17'd65536;
    if (r < 30) return '0;
    return WEIGHT_W'($urandom_range(65536, 0));
  endfunction

  // mostly a small working set so y entries build up between reads
  function automatic logic [POSE_W-1:0] pick_pose(int np);
    int r;
    r = $urandom_range(99, 0);
    if (r < 8) return '0;
    if (r < 16 && np < MAX_POSES) return POSE_W'($urandom_range(MAX_POSES - 1, np));
    if (r < 24) return POSE_W'(np - 1);
    if (r < 40) return POSE_W'($urandom_range(np - 1, 0));
    if (np < 2) return '0;
    return POSE_W'($urandom_range((np - 1 < 12) ? np - 1 : 12, 1));
  endfunction

  function automatic graph_item_t random_fill();
    graph_item_t it;
    int np;
    np = board.poses_used();
    it.op = OP_W'($urandom_range(3, 0));
    it.pose_index = pick_pose(np);
    it.component = COMP_W'($urandom_range(2, 0));
    it.x_value = rand_x();
    it.first_pose = pick_pose(np);
    it.second_pose = pick_pose(np);
    it.tau_value = rand_tau();
    it.weight_value = rand_weight();
    return it;
  endfunction

  function automatic graph_item_t mk_load(int pose, int c, logic signed [X_W-1:0] x);
    graph_item_t it;
    it = random_fill();
    it.op = OP_LOAD;
    it.pose_index = POSE_W'(pose);
    it.component = COMP_W'(c);
    it.x_value = x;
    return it;
  endfunction

  function automatic graph_item_t mk_read(int pose, int c);
    graph_item_t it;
    it = random_fill();
    it.op = OP_READ;
    it.pose_index = POSE_W'(pose);
    it.component = COMP_W'(c);
    return it;
  endfunction

  function automatic graph_item_t mk_edge(logic [OP_W-1:0] op, int p1, int p2,
                                          logic [TAU_W-1:0] tau, logic [WEIGHT_W-1:0] w);
    graph_item_t it;
    it = random_fill();
    it.op = op;
    it.first_pose = POSE_W'(p1);
    it.second_pose = POSE_W'(p2);
    it.tau_value = tau;
    it.weight_value = w;
    return it;
  endfunction

  task automatic push_item(graph_item_t it);
    if ($urandom_range(99, 0) < send_gap) begin
      item_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_gap);
    end
    item_ch.op <= it.op;
    item_ch.pose_index <= it.pose_index;
    item_ch.component <= it.component;
    item_ch.x_value <= it.x_value;
    item_ch.first_pose <= it.first_pose;
    item_ch.second_pose <= it.second_pose;
    item_ch.tau_value <= it.tau_value;
    item_ch.weight_value <= it.weight_value;
    item_ch.valid <= 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    board.note_item(it);
  endtask

  task automatic hold_until_drained();
    item_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ch.ready);
    board.set_reg(idx, CFG_DATA_W'(val));
  endtask

  task automatic configure(int dim, int poses, int weighted);
    write_reg(REG_DIMENSION, dim);
    write_reg(REG_POSE_COUNT, poses);
    write_reg(REG_USE_WEIGHT, weighted);
    cfg_ch.valid <= 1'b0;
  endtask

  // load any x entry an edge apply would read before it is written
  task automatic prime_pose(logic [POSE_W-1:0] pose);
    int c;
    int dim;
    if (pose == 0) return;
    dim = board.dims_used();
    for (c = 0; c < dim; c++) begin
      if (!board.x_set[int'(pose) * MAX_DIM + c]) push_item(mk_load(int'(pose), c, rand_x()));
    end
  endtask

  task automatic random_item();
    graph_item_t it;
    int r;
    int np;
    np = board.poses_used();
    it = random_fill();
    r = $urandom_range(99, 0);
    if (r < 25) it.op = OP_LOAD;
    else if (r < 60) it.op = OP_EDGE;
    else if (r < 75) it.op = OP_DIAG;
    else it.op = OP_READ;
    if (it.op == OP_EDGE && it.first_pose < np && it.second_pose < np) begin
      prime_pose(it.first_pose);
      prime_pose(it.second_pose);
    end
    push_item(it);
  endtask

  // drive one pose pair into both saturation limits, then read them out
  task automatic saturate_pair();
    int c;
    int k;
    for (c = 0; c < MAX_DIM; c++) begin
      push_item(mk_load(1000, c, 32'h7FFF_FFFF));
      push_item(mk_load(999, c, 32'h8000_0000));
    end
    for (k = 0; k < 140; k++)
      push_item(mk_edge(OP_EDGE, 999, 1000, TAU_MAX - TAU_W'($urandom_range(255, 0)),
                        17'd65536));
    for (c = 0; c < MAX_DIM; c++) begin
      push_item(mk_read(1000, c));
      push_item(mk_read(999, c));
    end
  endtask

  task automatic run_segment(int n, bit with_pump);
    int i;
    if (with_pump) saturate_pair();
    for (i = 0; i < n; i++) begin
      if (i == n / 2) hold_until_drained();
      random_item();
    end
  endtask

  initial begin
    #8_000_000;
    $display("FAIL weighted_graph_laplacian_matvec");
    $finish;
  end

  initial begin
    int s;
    int c;
    board = new();
    send_gap = 21;
    recv_gap = 80;
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.op <= OP_LOAD;
    item_ch.pose_index <= '0;
    item_ch.component <= '0;
    item_ch.x_value <= '0;
    item_ch.first_pose <= '0;
    item_ch.second_pose <= '0;
    item_ch.tau_value <= '0;
    item_ch.weight_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_DIMENSION;
    cfg_ch.data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: full extremes of x, rounding halves, self loops, anchor
    push_item(mk_load(1, 0, 32'h8000_0000));
    push_item(mk_load(1, 1, 32'h7FFF_FFFF));
    push_item(mk_load(1, 2, 32'h0000_8000));
    push_item(mk_load(1023, 0, 32'h7FFF_FFFF));
    push_item(mk_load(1023, 1, 32'h8000_0000));
    push_item(mk_load(1023, 2, 32'h0000_0000));
    push_item(mk_load(0, 1, 32'h0000_0005));
    push_item(mk_edge(OP_EDGE, 1, 1023, TAU_MAX, 17'd65536));
    push_item(mk_edge(OP_EDGE, 0, 1, 24'd1, 17'd0));
    push_item(mk_edge(OP_EDGE, 1, 0, 24'd1, 17'd0));
    push_item(mk_edge(OP_EDGE, 1, 1, rand_tau(), rand_weight()));
    push_item(mk_edge(OP_DIAG, 1023, 1023, TAU_MAX, 17'd0));
    push_item(mk_edge(OP_DIAG, 0, 1, 24'h01_0000, 17'd0));
    for (c = 0; c < MAX_DIM; c++) begin
      push_item(mk_read(1, c));
      push_item(mk_read(1023, c));
    end
    push_item(mk_read(0, 0));
    hold_until_drained();

    // narrow settings: bad component, bad pose, weighted precision
    configure(1, 2, 1);
    push_item(mk_load(1, 1, rand_x()));
    push_item(mk_read(2, 0));
    push_item(mk_edge(OP_EDGE, 0, 5, rand_tau(), rand_weight()));
    push_item(mk_edge(OP_DIAG, 3, 1, rand_tau(), rand_weight()));
    push_item(mk_edge(OP_EDGE, 0, 1, TAU_MAX, 17'd65536));
    push_item(mk_edge(OP_EDGE, 1, 0, 24'd1, 17'd32768));
    push_item(mk_edge(OP_DIAG, 1, 1, TAU_MAX, 17'd0));
    push_item(mk_read(1, 0));
    hold_until_drained();

    for (s = 0; s < 9; s++) begin
      if (s == 3) begin
        send_gap = 80;
        recv_gap = 21;
      end else if (s == 6) begin
        send_gap = 0;
        recv_gap = 0;
      end
      configure(seg_dim[s], seg_poses[s], seg_weight[s]);
      run_segment(seg_len[s], s == 7);
      hold_until_drained();
    end

    repeat (40) @(posedge clk);
    if (board.fails == 0) begin
      $display("PASS weighted_graph_laplacian_matvec");
    end else begin
      $display("FAIL weighted_graph_laplacian_matvec");
    end
    $finish;
  end

endmodule

/* weighted_graph_laplacian_matvec.f */
design/wglm_pkg.sv
design/wglm_if.sv
design/weighted_graph_laplacian_matvec.sv
verif/tb_weighted_graph_laplacian_matvec.sv
